// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked only outside reset.
`define GTZ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every edge, reset included.
`define GTZ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTZ_ASSERT(lbl, clk, rst, prop, msg)
`define GTZ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/gtz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gtz_pkg;

  localparam int DEF_BINS      = 4;
  localparam int DEF_ACC_WIDTH = 48;

  localparam int SMP_W     = 16;
  localparam int COEF_W    = 16;
  localparam int OUT_W     = 48;
  localparam int BIN_IDX_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS = 14;

  // Low bit of a register index picks cosine or sine.
  localparam logic COEF_SEL_COS = 1'b0;
  localparam logic COEF_SEL_SIN = 1'b1;

  localparam logic signed [COEF_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SIN_RESET = 16'sd0;

  // One accepted sample as seen by the lanes and the result unit.
  typedef struct packed {
    logic accept;
    logic block_end;
  } gtz_step_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gtz_smp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gtz_smp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [gtz_pkg::SMP_W-1:0]      sample;
  logic                                  block_end;

  modport source (output valid, output sample, output block_end, input ready);
  modport sink   (input valid, input sample, input block_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gtz_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gtz_res_if;
  logic                                  valid;
  logic                                  ready;
  logic [gtz_pkg::BIN_IDX_W-1:0]         bin_index;
  logic signed [gtz_pkg::OUT_W-1:0]      real_part;
  logic signed [gtz_pkg::OUT_W-1:0]      imag_part;
  logic                                  final_bin;

  modport source (output valid, output bin_index, output real_part, output imag_part,
                  output final_bin, input ready);
  modport sink   (input valid, input bin_index, input real_part, input imag_part,
                  input final_bin, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gtz_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gtz_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [gtz_pkg::CFG_IDX_W-1:0]         index;
  logic [gtz_pkg::COEF_W-1:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gtz_coef_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtz_coef_regs #(
  parameter int BINS = gtz_pkg::DEF_BINS
) (
  input  logic                                clk,
  input  logic                                rst,
  gtz_cfg_if.sink                             cfg,
  output logic signed [gtz_pkg::COEF_W-1:0]   cos_coef [BINS],
  output logic signed [gtz_pkg::COEF_W-1:0]   sin_coef [BINS]
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  // Writes to bins that are not built are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BINS; k++) begin
        cos_coef[k] <= gtz_pkg::COS_RESET;
        sin_coef[k] <= gtz_pkg::SIN_RESET;
      end
    end else if (wr) begin
      for (int k = 0; k < BINS; k++) begin
        if (cfg.index[gtz_pkg::CFG_IDX_W-1:1] == gtz_pkg::BIN_IDX_W'(k)) begin
          if (cfg.index[0] == gtz_pkg::COEF_SEL_COS) begin
            cos_coef[k] <= $signed(cfg.data);
          end else begin
            sin_coef[k] <= $signed(cfg.data);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gtz_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtz_lane #(
  parameter int ACC_WIDTH = gtz_pkg::DEF_ACC_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gtz_pkg::gtz_step_t                  step,
  input  logic signed [gtz_pkg::SMP_W-1:0]    sample,
  input  logic signed [gtz_pkg::COEF_W-1:0]   cos_coef,
  output logic signed [ACC_WIDTH-1:0]         prev,
  output logic signed [ACC_WIDTH-1:0]         prev2,
  output logic signed [ACC_WIDTH-1:0]         prev_next
);

  localparam int TWOC_W = gtz_pkg::COEF_W + 1;
  localparam int PROD_W = ACC_WIDTH + TWOC_W;
  localparam int SHR_W  = PROD_W - gtz_pkg::FRAC_BITS;
  localparam int SUM_W  = SHR_W + 2;

  logic signed [TWOC_W-1:0] twoc;
  logic signed [PROD_W-1:0] prod;
  logic signed [SHR_W-1:0]  shr;
  logic signed [SUM_W-1:0]  sum;
  logic                     in_range;

  assign twoc = $signed({cos_coef, 1'b0});
  assign prod = PROD_W'(prev) * PROD_W'(twoc);
  assign shr  = $signed(prod[PROD_W-1:gtz_pkg::FRAC_BITS]);
  assign sum  = SUM_W'(shr) + SUM_W'(sample) - SUM_W'(prev2);

  // The sum fits when all bits above the accumulator's sign bit agree with it.
  assign in_range  = (&sum[SUM_W-1:ACC_WIDTH-1]) | ~(|sum[SUM_W-1:ACC_WIDTH-1]);
  assign prev_next = in_range ? sum[ACC_WIDTH-1:0]
                              : {sum[SUM_W-1], {(ACC_WIDTH-1){~sum[SUM_W-1]}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      prev2 <= '0;
    end else if (step.accept) begin
      if (step.block_end) begin
        prev  <= '0;
        prev2 <= '0;
      end else begin
        prev  <= prev_next;
        prev2 <= prev;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gtz_result.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtz_result #(
  parameter int BINS      = gtz_pkg::DEF_BINS,
  parameter int ACC_WIDTH = gtz_pkg::DEF_ACC_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gtz_pkg::gtz_step_t                  step,
  input  logic signed [ACC_WIDTH-1:0]         snap_prev  [BINS],
  input  logic signed [ACC_WIDTH-1:0]         snap_prev2 [BINS],
  input  logic signed [gtz_pkg::COEF_W-1:0]   cos_coef   [BINS],
  input  logic signed [gtz_pkg::COEF_W-1:0]   sin_coef   [BINS],
  gtz_res_if.source                           res,
  output logic                                busy
);

  localparam int CNT_W  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int OW     = (ACC_WIDTH < gtz_pkg::OUT_W) ? ACC_WIDTH : gtz_pkg::OUT_W;
  localparam int PROD_W = ACC_WIDTH + gtz_pkg::COEF_W;
  localparam int SHR_W  = PROD_W - gtz_pkg::FRAC_BITS;
  localparam int RE_W   = SHR_W + 1;
  localparam logic [CNT_W-1:0] LAST_BIN = CNT_W'(BINS - 1);

  logic signed [ACC_WIDTH-1:0] bank_prev  [BINS];
  logic signed [ACC_WIDTH-1:0] bank_prev2 [BINS];
  logic [CNT_W-1:0]            bin_cnt;
  logic                        advance;

  logic signed [PROD_W-1:0] re_prod;
  logic signed [PROD_W-1:0] im_prod;
  logic signed [SHR_W-1:0]  im_shr;
  logic signed [RE_W-1:0]   re_sum;
  logic signed [OW-1:0]     re_sat;
  logic signed [OW-1:0]     im_sat;
  logic                     re_ok;
  logic                     im_ok;

  assign advance = busy && (!res.valid || res.ready);

  assign re_prod = PROD_W'(bank_prev[bin_cnt]) * PROD_W'(cos_coef[bin_cnt]);
  assign im_prod = PROD_W'(bank_prev[bin_cnt]) * PROD_W'(sin_coef[bin_cnt]);
  assign re_sum  = RE_W'($signed(re_prod[PROD_W-1:gtz_pkg::FRAC_BITS]))
                 - RE_W'(bank_prev2[bin_cnt]);
  assign im_shr  = $signed(im_prod[PROD_W-1:gtz_pkg::FRAC_BITS]);

  assign re_ok  = (&re_sum[RE_W-1:OW-1]) | ~(|re_sum[RE_W-1:OW-1]);
  assign im_ok  = (&im_shr[SHR_W-1:OW-1]) | ~(|im_shr[SHR_W-1:OW-1]);
  assign re_sat = re_ok ? re_sum[OW-1:0] : {re_sum[RE_W-1], {(OW-1){~re_sum[RE_W-1]}}};
  assign im_sat = im_ok ? im_shr[OW-1:0] : {im_shr[SHR_W-1], {(OW-1){~im_shr[SHR_W-1]}}};

  // Snapshot of the finished block; taken only while the bank is free.
  always_ff @(posedge clk) begin
    if (step.accept && step.block_end) begin
      for (int k = 0; k < BINS; k++) begin
        bank_prev[k]  <= snap_prev[k];
        bank_prev2[k] <= snap_prev2[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bin_cnt   <= '0;
      res.valid <= 1'b0;
    end else begin
      if (advance) begin
        res.valid <= 1'b1;
        if (bin_cnt == LAST_BIN) begin
          busy    <= 1'b0;
          bin_cnt <= '0;
        end else begin
          bin_cnt <= bin_cnt + 1'b1;
        end
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (step.accept && step.block_end) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.bin_index <= gtz_pkg::BIN_IDX_W'(bin_cnt);
      res.real_part <= gtz_pkg::OUT_W'(re_sat);
      res.imag_part <= gtz_pkg::OUT_W'(im_sat);
      res.final_bin <= (bin_cnt == LAST_BIN);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_bin_goertzel.sv =====
// Channel   Direction  Words carried
// --------  ---------  ---------------------------------------------------
// cfg       in         coefficient writes: index (cos 2k, sin 2k+1), data
// samples   in         one signed sample per word, block_end on the last
// results   out        one word per bin at block end: bin, real, imag, last
//
// Every bin updates in parallel, so a sample word is taken in every cycle; the
// critical path is one ACC_WIDTH x 17 multiply, an add and saturation per lane.
// A block end hands the lane state to a result bank that drains one bin per
// unstalled cycle through shared multipliers into the output register.
// A block end word waits while that bank is still draining; other samples flow.
// Reset (rst, synchronous) clears the accumulators and restores cos 1.0, sin 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module multi_bin_goertzel #(
  parameter int BINS      = gtz_pkg::DEF_BINS,
  parameter int ACC_WIDTH = gtz_pkg::DEF_ACC_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  gtz_cfg_if.sink     cfg,
  gtz_smp_if.sink     samples,
  gtz_res_if.source   results
);

  // Coefficients: one cosine and one sine per bin, written through cfg.
  logic signed [gtz_pkg::COEF_W-1:0] cos_coef [BINS];
  logic signed [gtz_pkg::COEF_W-1:0] sin_coef [BINS];

  // Lane state and the value each lane would store on this sample.
  logic signed [ACC_WIDTH-1:0] prev      [BINS];
  logic signed [ACC_WIDTH-1:0] prev2     [BINS];
  logic signed [ACC_WIDTH-1:0] prev_next [BINS];

  gtz_pkg::gtz_step_t step;
  logic               res_busy;

  // The result bank holds one block at a time, so only a closing sample
  // has to wait for it; ordinary samples are always taken.
  assign samples.ready  = !(res_busy && samples.block_end);
  assign step.accept    = samples.valid && samples.ready;
  assign step.block_end = samples.block_end;

  gtz_coef_regs #(
    .BINS (BINS)
  ) u_coef (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cos_coef (cos_coef),
    .sin_coef (sin_coef)
  );

  // One resonator per bin: new = sample + 2*cos*prev - prev2, saturated.
  for (genvar k = 0; k < BINS; k++) begin : g_lane
    gtz_lane #(
      .ACC_WIDTH (ACC_WIDTH)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .sample    (samples.sample),
      .cos_coef  (cos_coef[k]),
      .prev      (prev[k]),
      .prev2     (prev2[k]),
      .prev_next (prev_next[k])
    );
  end

  // On the closing sample the bank takes the updated state: the new value
  // becomes prev and the old prev becomes prev2, as if the update had landed.
  gtz_result #(
    .BINS      (BINS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .snap_prev  (prev_next),
    .snap_prev2 (prev),
    .cos_coef   (cos_coef),
    .sin_coef   (sin_coef),
    .res        (results),
    .busy       (res_busy)
  );

  // A closing sample must never overwrite a bank that is still draining.
  `GTZ_ASSERT(a_no_bank_overrun, clk, rst, (step.accept && step.block_end) |-> !res_busy, "block end taken while result bank busy")
  // A taken closing sample always starts a drain.
  `GTZ_ASSERT(a_drain_starts, clk, rst, (step.accept && step.block_end) |=> res_busy, "result bank did not start draining")
  // The final bin of a block is only shown once the bank has finished.
  `GTZ_ASSERT(a_final_ends_drain, clk, rst, (results.valid && results.final_bin && !$stable(results.final_bin)) |-> !res_busy || $past(step.accept && step.block_end), "final bin shown while bank still draining")
  // Reset leaves no result word pending.
  `GTZ_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !results.valid, "result word valid after reset")

endmodule
`default_nettype wire
